// ===== rtl/core/shk_pkg.sv =====
// shared constants, types and status codes of the string key hash table
package shk_pkg;

	localparam int TABLE_SIZE = 4096;
	localparam int VOCAB_MAX  = 2048;
	localparam int MAX_LEN    = 32;

	localparam int TBL_W   = $clog2(TABLE_SIZE);
	localparam int IDX_W   = $clog2(VOCAB_MAX);
	localparam int KLEN_W  = $clog2(MAX_LEN);
	localparam int WADDR_W = IDX_W + KLEN_W;
	localparam int SLOT_W  = IDX_W + 1;
	localparam int WCNT_W  = IDX_W + 1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_MISS        = 2'd1;
	localparam logic [1:0] ST_STORE_FULL  = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL  = 2'd3;

	typedef struct packed {
		logic       take;
		logic       start;
		logic       clr_wr;
		logic       adv;
		logic       latch_w;
		logic       i_clr;
		logic       i_inc;
		logic       copy_wr;
		logic       claim;
		logic       res_set;
		logic [1:0] res_code;
		logic       res_found;
		logic       res_added;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic slot_valid;
		logic len_eq;
		logic len_zero;
		logic byte_eq;
		logic i_last;
		logic probe_end;
		logic clr_end;
		logic store_full;
		logic op_add;
	} sts_t;

endpackage

// ===== rtl/core/shk_if.sv =====
// handshake channels: byte items in, result items out
interface shk_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] key_byte;
	logic       last;

	modport source (output valid, output op, output key_byte, output last, input ready);
	modport sink (input valid, input op, input key_byte, input last, output ready);
endinterface

interface shk_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [10:0] index;
	logic        truncated;

	modport source (output valid, output status, output index, output truncated, input ready);
	modport sink (input valid, input status, input index, input truncated, output ready);
endinterface

// ===== rtl/core/string_key_hash_table.sv =====
// top level of the string key hash table
//   channel  dir  payload                          taken when
//   req      in   op, key_byte, last               req.valid && req.ready
//   rsp      out  status, index, truncated         rsp.valid && rsp.ready
// a byte that does not end a word is taken while the block stays in intake
// a word end probes slots from its hash on; a search compares stored length, then stored bytes
// an add reports a full store, else copies the key and claims a slot; ram reads are registered
// after reset a clearing pass empties all 4096 slots of the slot table, no item taken meanwhile
// a finished result waits in its output register; the next word's bytes are taken meanwhile
module string_key_hash_table (
	input logic    clk,
	input logic    arst_n,
	shk_in_if.sink  req,
	shk_out_if.source rsp
);
	import shk_pkg::*;

	cmd_t cmd;
	sts_t sts;

	shk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_last   (req.last),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	shk_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_op         (req.op),
		.in_key_byte   (req.key_byte),
		.out_status    (rsp.status),
		.out_index     (rsp.index),
		.out_truncated (rsp.truncated)
	);
endmodule

// ===== rtl/core/shk_ram.sv =====
// generic simple dual port ram with registered read
module shk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/shk_dpath.sv =====
// datapath: key buffer, hash, probe position, word store and result registers
module shk_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  shk_pkg::cmd_t               cmd,
	output shk_pkg::sts_t               sts,
	input  logic                        in_op,
	input  logic [7:0]                  in_key_byte,
	output logic [1:0]                  out_status,
	output logic [shk_pkg::IDX_W-1:0]   out_index,
	output logic                        out_truncated
);
	import shk_pkg::*;

	logic [TBL_W-1:0]  hash_q;
	logic [TBL_W-1:0]  pos_q;
	logic [TBL_W-1:0]  n_q;
	logic [TBL_W-1:0]  clr_q;
	logic [KLEN_W-1:0] klen_q;
	logic [KLEN_W-1:0] i_q;
	logic              cut_q;
	logic              op_q;
	logic [IDX_W-1:0]  w_q;
	logic [WCNT_W-1:0] wc_q;
	logic [1:0]        res_status_q;
	logic [IDX_W-1:0]  res_index_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  index_q;
	logic              trunc_q;

	logic [TBL_W-1:0]  ext_b;
	logic [TBL_W-1:0]  hash_nx;
	logic              keep;
	logic [7:0]        kb_rd;
	logic [7:0]        wb_rd;
	logic [KLEN_W-1:0] len_rd;
	logic [SLOT_W-1:0] slot_rd;
	logic              slot_we;
	logic [TBL_W-1:0]  slot_waddr;
	logic [SLOT_W-1:0] slot_wdata;

	// only the low hash bits pick the slot, and they depend on low bits alone
	assign ext_b   = {{(TBL_W - 8){in_key_byte[7]}}, in_key_byte};
	assign hash_nx = hash_q + (hash_q << 8) + ext_b;
	assign keep    = klen_q != KLEN_W'(MAX_LEN - 1);

	assign slot_we    = cmd.clr_wr | cmd.claim;
	assign slot_waddr = cmd.clr_wr ? clr_q : pos_q;
	assign slot_wdata = cmd.clr_wr ? '0 : {1'b1, wc_q[IDX_W-1:0]};

	shk_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_key_ram (
		.clk   (clk),
		.we    (cmd.take & keep),
		.waddr (klen_q),
		.wdata (in_key_byte),
		.raddr (i_q),
		.rdata (kb_rd)
	);

	shk_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SIZE)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (pos_q),
		.rdata (slot_rd)
	);

	shk_ram #(.WIDTH(KLEN_W), .DEPTH(VOCAB_MAX)) u_len_ram (
		.clk   (clk),
		.we    (cmd.claim),
		.waddr (wc_q[IDX_W-1:0]),
		.wdata (klen_q),
		.raddr (slot_rd[IDX_W-1:0]),
		.rdata (len_rd)
	);

	shk_ram #(.WIDTH(8), .DEPTH(VOCAB_MAX * MAX_LEN)) u_word_ram (
		.clk   (clk),
		.we    (cmd.copy_wr),
		.waddr ({wc_q[IDX_W-1:0], i_q}),
		.wdata (kb_rd),
		.raddr ({w_q, i_q}),
		.rdata (wb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			klen_q <= '0;
			cut_q  <= 1'b0;
			wc_q   <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.take) begin
				if (keep) begin
					hash_q <= hash_nx;
					klen_q <= klen_q + 1'b1;
				end else begin
					cut_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				hash_q <= '0;
				klen_q <= '0;
				cut_q  <= 1'b0;
			end
			if (cmd.claim) begin
				wc_q <= wc_q + 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q <= keep ? hash_nx : hash_q;
			op_q  <= in_op;
			n_q   <= '0;
		end
		if (cmd.adv) begin
			pos_q <= pos_q + 1'b1;
			n_q   <= n_q + 1'b1;
		end
		if (cmd.latch_w) begin
			w_q <= slot_rd[IDX_W-1:0];
		end
		if (cmd.i_clr) begin
			i_q <= '0;
		end else if (cmd.i_inc) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			if (cmd.res_found) begin
				res_index_q <= w_q;
			end else if (cmd.res_added) begin
				res_index_q <= wc_q[IDX_W-1:0];
			end else begin
				res_index_q <= '0;
			end
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			index_q  <= res_index_q;
			trunc_q  <= cut_q;
		end
	end

	always_comb begin
		sts.slot_valid = slot_rd[SLOT_W-1];
		sts.len_eq     = len_rd == klen_q;
		sts.len_zero   = klen_q == '0;
		sts.byte_eq    = kb_rd == wb_rd;
		sts.i_last     = i_q == klen_q - 1'b1;
		sts.probe_end  = n_q == TBL_W'(TABLE_SIZE - 1);
		sts.clr_end    = clr_q == TBL_W'(TABLE_SIZE - 1);
		sts.store_full = wc_q >= WCNT_W'(VOCAB_MAX);
		sts.op_add     = op_q;
	end

	assign out_status    = status_q;
	assign out_index     = index_q;
	assign out_truncated = trunc_q;

`ifndef SYNTHESIS
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= WCNT_W'(VOCAB_MAX)) else $error("word count beyond store size");
	a_claim_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim |-> !sts.store_full) else $error("word claimed in a full store");
	a_claim_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim |=> wc_q == $past(wc_q) + 1'b1) else $error("word count not advanced");
	a_copy_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_wr |-> !sts.len_zero) else $error("copy of an empty key");
`endif
endmodule

// ===== rtl/core/shk_ctrl.sv =====
// controller: byte intake, clearing pass, probe, compare and copy sequencing
module shk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output shk_pkg::cmd_t cmd,
	input  shk_pkg::sts_t sts
);
	import shk_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PRD  = 4'd2;
	localparam logic [3:0] S_PCHK = 4'd3;
	localparam logic [3:0] S_LCHK = 4'd4;
	localparam logic [3:0] S_CRD  = 4'd5;
	localparam logic [3:0] S_CCHK = 4'd6;
	localparam logic [3:0] S_ADV  = 4'd7;
	localparam logic [3:0] S_ARD  = 4'd8;
	localparam logic [3:0] S_AWR  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;
	localparam logic [3:0] S_RESP = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_end) state_nx = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_last) begin
						cmd.start = 1'b1;
						state_nx  = S_PRD;
					end
				end
			end
			S_PRD: begin
				if (sts.op_add && sts.store_full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_STORE_FULL;
					state_nx     = S_RESP;
				end else begin
					state_nx = S_PCHK;
				end
			end
			S_PCHK: begin
				if (!sts.slot_valid) begin
					if (sts.op_add) begin
						if (sts.len_zero) begin
							state_nx = S_FIN;
						end else begin
							cmd.i_clr = 1'b1;
							state_nx  = S_ARD;
						end
					end else begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_MISS;
						state_nx     = S_RESP;
					end
				end else if (sts.op_add) begin
					state_nx = S_ADV;
				end else begin
					cmd.latch_w = 1'b1;
					state_nx    = S_LCHK;
				end
			end
			S_LCHK: begin
				if (!sts.len_eq) begin
					state_nx = S_ADV;
				end else if (sts.len_zero) begin
					cmd.res_set   = 1'b1;
					cmd.res_code  = ST_OK;
					cmd.res_found = 1'b1;
					state_nx      = S_RESP;
				end else begin
					cmd.i_clr = 1'b1;
					state_nx  = S_CRD;
				end
			end
			S_CRD: begin
				state_nx = S_CCHK;
			end
			S_CCHK: begin
				if (!sts.byte_eq) begin
					state_nx = S_ADV;
				end else if (sts.i_last) begin
					cmd.res_set   = 1'b1;
					cmd.res_code  = ST_OK;
					cmd.res_found = 1'b1;
					state_nx      = S_RESP;
				end else begin
					cmd.i_inc = 1'b1;
					state_nx  = S_CRD;
				end
			end
			S_ADV: begin
				if (sts.probe_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = sts.op_add ? ST_TABLE_FULL : ST_MISS;
					state_nx     = S_RESP;
				end else begin
					cmd.adv  = 1'b1;
					state_nx = S_PRD;
				end
			end
			S_ARD: begin
				state_nx = S_AWR;
			end
			S_AWR: begin
				cmd.copy_wr = 1'b1;
				if (sts.i_last) begin
					state_nx = S_FIN;
				end else begin
					cmd.i_inc = 1'b1;
					state_nx  = S_ARD;
				end
			end
			S_FIN: begin
				cmd.claim     = 1'b1;
				cmd.res_set   = 1'b1;
				cmd.res_code  = ST_OK;
				cmd.res_added = 1'b1;
				state_nx      = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == S_IDLE && in_valid) else $error("item taken outside intake");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready) else $error("result overwritten");
	a_start_probe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == S_PRD) else $error("word end did not start probe");
	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim |-> sts.op_add) else $error("slot claimed by a search");
`endif
endmodule
